// ===== rtl/gregorian_date_difference_top_defines.svh =====
`ifndef GREGORIAN_DATE_DIFFERENCE_TOP_DEFINES_SVH
`define GREGORIAN_DATE_DIFFERENCE_TOP_DEFINES_SVH

// same-cycle check: when ante holds, cons must hold at that edge
`define GDD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle check: when ante holds, cons must hold at the following edge
`define GDD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/gdd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gdd_pkg;

    // field widths
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int NUM_W   = 23;
    localparam int QUOT_W  = 8;

    // year limits
    localparam logic [YEAR_W-1:0] YEAR_MIN = YEAR_W'(1);
    localparam logic [YEAR_W-1:0] YEAR_MAX = YEAR_W'(9999);

    // division by 100 as multiply by reciprocal, exact for values below 43699
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 19;
    localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(5243);
    localparam int PROD_W = YEAR_W + RECIP_W;

    localparam logic [NUM_W-1:0] YEAR_DAYS = NUM_W'(365);

    // month codes
    localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MONTH_MAR = MONTH_W'(3);
    localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

    // both dates as carried in the input item, first_day in the lowest bits
    typedef struct packed {
        logic [YEAR_W-1:0]  second_year;
        logic [MONTH_W-1:0] second_month;
        logic [DAY_W-1:0]   second_day;
        logic [YEAR_W-1:0]  first_year;
        logic [MONTH_W-1:0] first_month;
        logic [DAY_W-1:0]   first_day;
    } t_date_pair;

    localparam int PAIR_W = $bits(t_date_pair);

    // length of a month, february by leap flag; zero for codes with no month
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
            4'd4, 4'd6, 4'd9, 4'd11:                  len = DAY_W'(30);
            4'd2:    len = leap ? DAY_W'(29) : DAY_W'(28);
            default: len = '0;
        endcase
        return len;
    endfunction

    // days before the month in a year that starts in march
    function automatic logic [8:0] march_offset(input logic [MONTH_W-1:0] m);
        logic [8:0] off;
        unique case (m)
            4'd3:    off = 9'd0;
            4'd4:    off = 9'd31;
            4'd5:    off = 9'd61;
            4'd6:    off = 9'd92;
            4'd7:    off = 9'd122;
            4'd8:    off = 9'd153;
            4'd9:    off = 9'd184;
            4'd10:   off = 9'd214;
            4'd11:   off = 9'd245;
            4'd12:   off = 9'd275;
            4'd1:    off = 9'd306;
            4'd2:    off = 9'd337;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/gdd_day_number.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gdd_day_number (
    input  wire logic [gdd_pkg::DAY_W-1:0]   i_day,
    input  wire logic [gdd_pkg::MONTH_W-1:0] i_month,
    input  wire logic [gdd_pkg::YEAR_W-1:0]  i_year,
    output logic      [gdd_pkg::NUM_W-1:0]   o_day_num,
    output logic                             o_valid
);

    logic [gdd_pkg::YEAR_W-1:0] year_m1;
    logic [gdd_pkg::PROD_W-1:0] prod_y;
    logic [gdd_pkg::PROD_W-1:0] prod_ym1;
    logic [gdd_pkg::QUOT_W-1:0] q_y;
    logic [gdd_pkg::QUOT_W-1:0] q_ym1;
    logic                       century;
    logic                       leap;
    logic                       early;
    logic [gdd_pkg::YEAR_W-1:0] ya;
    logic [gdd_pkg::QUOT_W-1:0] qa;
    logic [gdd_pkg::DAY_W-1:0]  len;

    // year / 100 for the year and the year before, in parallel
    assign year_m1  = i_year - gdd_pkg::YEAR_W'(1);
    assign prod_y   = gdd_pkg::PROD_W'(i_year) * gdd_pkg::PROD_W'(gdd_pkg::RECIP_100);
    assign prod_ym1 = gdd_pkg::PROD_W'(year_m1) * gdd_pkg::PROD_W'(gdd_pkg::RECIP_100);
    assign q_y      = prod_y[gdd_pkg::RECIP_SHIFT +: gdd_pkg::QUOT_W];
    assign q_ym1    = prod_ym1[gdd_pkg::RECIP_SHIFT +: gdd_pkg::QUOT_W];

    // century year when the quotient steps; divisible by 400 when it is a multiple of 4
    assign century = (q_y != q_ym1) && (i_year != '0);
    assign leap    = ((i_year[1:0] == 2'b00) && !century)
                   || (century && (q_y[1:0] == 2'b00));

    // january and february count in the previous march-based year
    assign early = (i_month < gdd_pkg::MONTH_MAR);
    assign ya    = early ? year_m1 : i_year;
    assign qa    = early ? q_ym1 : q_y;

    // day count since the epoch
    assign o_day_num = (gdd_pkg::YEAR_DAYS * gdd_pkg::NUM_W'(ya))
                     + gdd_pkg::NUM_W'(ya >> 2)
                     - gdd_pkg::NUM_W'(qa)
                     + gdd_pkg::NUM_W'(qa >> 2)
                     + gdd_pkg::NUM_W'(gdd_pkg::march_offset(i_month))
                     + gdd_pkg::NUM_W'(i_day);

    // range checks
    assign len     = gdd_pkg::month_len(i_month, leap);
    assign o_valid = (i_year >= gdd_pkg::YEAR_MIN) && (i_year <= gdd_pkg::YEAR_MAX)
                   && (i_month >= gdd_pkg::MONTH_JAN) && (i_month <= gdd_pkg::MONTH_DEC)
                   && (i_day != '0) && (i_day <= len);

endmodule

`default_nettype wire

// ===== rtl/gregorian_date_difference_top.sv =====
// an accepted item goes from the input register through the result register to the output
// throughput: one item per cycle while the output is not stalled, set by a single pass
//   from the input register through both day-number converters into the result register
// reset: synchronous, active low; both stages are emptied, no item in flight
`timescale 1ns / 1ps
`default_nettype none

`include "gregorian_date_difference_top_defines.svh"

module gregorian_date_difference_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // first_day, first_month, first_year, second_day, second_month, second_year
    input  wire logic [47:0] i_s_tdata,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // day_difference
    output logic [23:0]      o_m_tdata,
    // date_invalid
    output logic             o_m_tuser
);

    gdd_pkg::t_date_pair             r_s1_data;
    logic                            r_s1_valid;
    logic                            r_out_valid;
    logic [gdd_pkg::NUM_W-1:0]       r_out_diff;
    logic                            r_out_inv;

    logic                            out_adv;
    logic [gdd_pkg::NUM_W-1:0]       num1;
    logic [gdd_pkg::NUM_W-1:0]       num2;
    logic                            ok1;
    logic                            ok2;
    logic [gdd_pkg::NUM_W-1:0]       n_out_diff;
    logic                            n_out_inv;

    // stage handshakes
    assign out_adv    = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_s1_valid || out_adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_valid <= i_s_tvalid;
        end
        if (o_s_tready && i_s_tvalid) begin
            r_s1_data <= gdd_pkg::t_date_pair'(i_s_tdata[gdd_pkg::PAIR_W-1:0]);
        end
    end

    // day numbers of both dates
    gdd_day_number u_num1 (
        .i_day     (r_s1_data.first_day),
        .i_month   (r_s1_data.first_month),
        .i_year    (r_s1_data.first_year),
        .o_day_num (num1),
        .o_valid   (ok1)
    );

    gdd_day_number u_num2 (
        .i_day     (r_s1_data.second_day),
        .i_month   (r_s1_data.second_month),
        .i_year    (r_s1_data.second_year),
        .o_day_num (num2),
        .o_valid   (ok2)
    );

    // difference, forced to zero on a bad date
    assign n_out_inv  = !(ok1 && ok2);
    assign n_out_diff = n_out_inv ? '0 : (num2 - num1);

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_s1_valid;
        end
        if (out_adv && r_s1_valid) begin
            r_out_diff <= n_out_diff;
            r_out_inv  <= n_out_inv;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_diff};
    assign o_m_tuser  = r_out_inv;

    // checks
    `GDD_ASSERT_NOW(a_inv_zero, o_m_tvalid && o_m_tuser, r_out_diff == '0, "bad date diff")
    `GDD_ASSERT_NEXT(a_take_in, i_s_tvalid && o_s_tready, r_s1_valid, "input item lost")
    `GDD_ASSERT_NEXT(a_move_out, r_s1_valid && out_adv, r_out_valid, "item lost between stages")
    `GDD_ASSERT_NOW(a_full_stall, r_s1_valid && !out_adv, !o_s_tready, "ready while full")

endmodule

`default_nettype wire
